// File: sv/tcm_pkg.sv
// tcm_pkg: shared types, widths and register indexes for the touch coordinate mapper.
// No dependencies; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package tcm_pkg;

    localparam int COORD_BITS     = 12;   // chip and screen coordinate width
    localparam int NIB_BITS       = 4;
    localparam int SIZE_BITS      = 13;   // screen size register width
    localparam int OFFSET_BITS    = 13;   // one signed offset
    localparam int ORIENT_BITS    = 3;
    localparam int CFG_DATA_BITS  = 26;
    localparam int CFG_INDEX_BITS = 3;
    localparam int NUM_AXES       = 2;    // axis 0 feeds screen X, axis 1 screen Y

    localparam logic [SIZE_BITS-1:0] SCREEN_LIMIT = 13'd4096;

    localparam int ORIENT_SWAP     = 0;
    localparam int ORIENT_MIRROR_X = 1;
    localparam int ORIENT_MIRROR_Y = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_RAW_MIN_X     = 3'd0,
        REG_RAW_MAX_X     = 3'd1,
        REG_RAW_MIN_Y     = 3'd2,
        REG_RAW_MAX_Y     = 3'd3,
        REG_SCREEN_WIDTH  = 3'd4,
        REG_SCREEN_HEIGHT = 3'd5,
        REG_ORIENTATION   = 3'd6,
        REG_OFFSET_PAIR   = 3'd7
    } cfg_reg_t;

    // Settings used by the back end of the pipeline
    typedef struct packed {
        logic [COORD_BITS-1:0]  wm1;      // effective width minus one
        logic [COORD_BITS-1:0]  hm1;      // effective height minus one
        logic [ORIENT_BITS-1:0] orient;
        logic [OFFSET_BITS-1:0] off_x;
        logic [OFFSET_BITS-1:0] off_y;
    } post_cfg_t;

    // Size register to last valid coordinate; 0 acts as 1, above 4096 acts as 4096
    function automatic logic [COORD_BITS-1:0] size_m1(input logic [SIZE_BITS-1:0] s);
        logic [SIZE_BITS-1:0] d;
        d = s - 13'd1;
        if (s == '0)
            return '0;
        else if (s > SCREEN_LIMIT)
            return '1;
        else
            return d[COORD_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// File: sv/tcm_front.sv
// tcm_front: unpacks a report, clamps both raw coordinates into their windows
// and forms the scaled dividend. Two register stages. Depends on tcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcm_front import tcm_pkg::*; #(
    parameter int RAW_COORD_BITS = 12,
    localparam int RW = (RAW_COORD_BITS > COORD_BITS) ? RAW_COORD_BITS : COORD_BITS,
    localparam int PW = RW + COORD_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              read_ok,
    input  wire logic [7:0]                        chip_x_high,
    input  wire logic [7:0]                        chip_y_high,
    input  wire logic [7:0]                        low_nibbles,
    input  wire logic [7:0]                        count_byte,
    input  wire logic [RW-1:0]                     cal_lo_x,
    input  wire logic [RW-1:0]                     cal_hi_x,
    input  wire logic [RW-1:0]                     cal_lo_y,
    input  wire logic [RW-1:0]                     cal_hi_y,
    input  wire logic [COORD_BITS-1:0]             wm1,
    input  wire logic [COORD_BITS-1:0]             hm1,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   out_pressed,
    output logic [NUM_AXES-1:0][PW-1:0]            out_prod,
    output logic [NUM_AXES-1:0][RW-1:0]            out_span
);

    logic [NUM_AXES-1:0][RW-1:0]         raw, lo, hi, span_next, norm_next, diff;
    logic [NUM_AXES-1:0][COORD_BITS-1:0] sm1;
    logic                                pressed_next;
    logic                                adv_a, adv_b;

    logic                                va_reg, vb_reg;
    logic                                pa_reg, pb_reg;
    logic [NUM_AXES-1:0][RW-1:0]         norm_reg, span_a_reg, span_b_reg;
    logic [NUM_AXES-1:0][PW-1:0]         prod_reg;

    // chip Y drives screen X, chip X drives screen Y
    assign raw[0] = RW'({chip_y_high, low_nibbles[NIB_BITS-1:0]});
    assign raw[1] = RW'({chip_x_high, low_nibbles[2*NIB_BITS-1:NIB_BITS]});
    assign lo[0]  = cal_lo_y;
    assign hi[0]  = cal_hi_y;
    assign lo[1]  = cal_lo_x;
    assign hi[1]  = cal_hi_x;
    assign sm1[0] = wm1;
    assign sm1[1] = hm1;

    assign pressed_next = read_ok && (count_byte[NIB_BITS-1:0] != '0);

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            span_next[a] = (hi[a] > lo[a]) ? (hi[a] - lo[a]) : RW'(1);
            diff[a]      = (raw[a] > lo[a]) ? (raw[a] - lo[a]) : '0;
            norm_next[a] = (diff[a] > span_next[a]) ? span_next[a] : diff[a];
        end
    end

    assign adv_b    = !vb_reg || out_ready;
    assign adv_a    = !va_reg || adv_b;
    assign in_ready = adv_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (adv_a)
                va_reg <= in_valid;
            if (adv_b)
                vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_a)
        begin
            pa_reg     <= pressed_next;
            norm_reg   <= norm_next;
            span_a_reg <= span_next;
        end
        if (adv_b)
        begin
            pb_reg     <= pa_reg;
            span_b_reg <= span_a_reg;
            for (int a = 0; a < NUM_AXES; a++)
                prod_reg[a] <= PW'(norm_reg[a]) * PW'(sm1[a]);
        end
    end

    assign out_valid   = vb_reg;
    assign out_pressed = pb_reg;
    assign out_prod    = prod_reg;
    assign out_span    = span_b_reg;

endmodule

`default_nettype wire

// File: sv/tcm_div.sv
// tcm_div: restoring divider for both axes, one quotient bit per register stage.
// Dividend is below span times 2**COORD_BITS, so the quotient fits. Depends on tcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcm_div import tcm_pkg::*; #(
    parameter int RAW_COORD_BITS = 12,
    localparam int RW = (RAW_COORD_BITS > COORD_BITS) ? RAW_COORD_BITS : COORD_BITS,
    localparam int PW = RW + COORD_BITS
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic                                  in_pressed,
    input  wire logic [NUM_AXES-1:0][PW-1:0]           in_prod,
    input  wire logic [NUM_AXES-1:0][RW-1:0]           in_span,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic                                       out_pressed,
    output logic [NUM_AXES-1:0][COORD_BITS-1:0]        out_quot
);

    localparam int NSTG = COORD_BITS;

    logic [NSTG-1:0]                         v_reg;
    logic [NSTG-1:0]                         p_reg;
    logic [NSTG:0]                           adv;
    logic [NUM_AXES-1:0][PW-1:0]             rem_reg  [NSTG];
    logic [NUM_AXES-1:0][RW-1:0]             span_reg [NSTG];
    logic [NUM_AXES-1:0][COORD_BITS-1:0]     quot_reg [NSTG];

    assign adv[NSTG] = out_ready;

    for (genvar s = 0; s < NSTG; s++)
    begin : g_stage
        localparam int BIT = NSTG - 1 - s;

        logic                                 v_in, p_in;
        logic [NUM_AXES-1:0][PW-1:0]          rem_in, rem_next, trial;
        logic [NUM_AXES-1:0][RW-1:0]          span_in;
        logic [NUM_AXES-1:0][COORD_BITS-1:0]  quot_in, quot_next;

        if (s == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign p_in    = in_pressed;
            assign rem_in  = in_prod;
            assign span_in = in_span;
            assign quot_in = '0;
        end
        else
        begin : g_rest
            assign v_in    = v_reg[s-1];
            assign p_in    = p_reg[s-1];
            assign rem_in  = rem_reg[s-1];
            assign span_in = span_reg[s-1];
            assign quot_in = quot_reg[s-1];
        end

        always_comb
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                trial[a]     = PW'(span_in[a]) << BIT;
                rem_next[a]  = rem_in[a];
                quot_next[a] = quot_in[a];
                if (rem_in[a] >= trial[a])
                begin
                    rem_next[a]       = rem_in[a] - trial[a];
                    quot_next[a][BIT] = 1'b1;
                end
            end
        end

        assign adv[s] = !v_reg[s] || adv[s+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (adv[s])
                v_reg[s] <= v_in;
        end

        always_ff @(posedge clk)
        begin
            if (adv[s])
            begin
                p_reg[s]    <= p_in;
                rem_reg[s]  <= rem_next;
                span_reg[s] <= span_in;
                quot_reg[s] <= quot_next;
            end
        end
    end

    assign in_ready    = adv[0];
    assign out_valid   = v_reg[NSTG-1];
    assign out_pressed = p_reg[NSTG-1];
    assign out_quot    = quot_reg[NSTG-1];

endmodule

`default_nettype wire

// File: sv/tcm_post.sv
// tcm_post: swap, clamp to screen, mirror, then signed offset with clamping.
// Two register stages; the second is the output register. Depends on tcm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcm_post import tcm_pkg::*; (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                in_pressed,
    input  wire logic [NUM_AXES-1:0][COORD_BITS-1:0] in_quot,
    input  wire post_cfg_t                           cfg,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic                                     pressed,
    output logic [COORD_BITS-1:0]                    screen_x,
    output logic [COORD_BITS-1:0]                    screen_y
);

    localparam int SUM_BITS = COORD_BITS + 3;

    logic [NUM_AXES-1:0][COORD_BITS-1:0]  swp, clmp, mir_next, lim;
    logic [NUM_AXES-1:0][OFFSET_BITS-1:0] off;
    logic [NUM_AXES-1:0][SUM_BITS-1:0]    sum;
    logic [NUM_AXES-1:0][COORD_BITS-1:0]  fin_next;
    logic                                 adv_a, adv_b;

    logic                                 va_reg, vb_reg, pa_reg, pb_reg;
    logic [NUM_AXES-1:0][COORD_BITS-1:0]  mir_reg, fin_reg;

    assign lim[0] = cfg.wm1;
    assign lim[1] = cfg.hm1;
    assign off[0] = cfg.off_x;
    assign off[1] = cfg.off_y;

    always_comb
    begin
        if (cfg.orient[ORIENT_SWAP])
        begin
            swp[0] = in_quot[1];
            swp[1] = in_quot[0];
        end
        else
        begin
            swp = in_quot;
        end
        for (int a = 0; a < NUM_AXES; a++)
            clmp[a] = (swp[a] > lim[a]) ? lim[a] : swp[a];
        // clamped first, so the mirror never wraps
        mir_next[0] = cfg.orient[ORIENT_MIRROR_X] ? (lim[0] - clmp[0]) : clmp[0];
        mir_next[1] = cfg.orient[ORIENT_MIRROR_Y] ? (lim[1] - clmp[1]) : clmp[1];
    end

    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            sum[a] = SUM_BITS'(mir_reg[a]) +
                     {{(SUM_BITS-OFFSET_BITS){off[a][OFFSET_BITS-1]}}, off[a]};
            if (!pa_reg || sum[a][SUM_BITS-1])
                fin_next[a] = '0;
            else if (sum[a][SUM_BITS-2:0] > (SUM_BITS-1)'(lim[a]))
                fin_next[a] = lim[a];
            else
                fin_next[a] = sum[a][COORD_BITS-1:0];
        end
    end

    assign adv_b    = !vb_reg || !out_stall;
    assign adv_a    = !va_reg || adv_b;
    assign in_ready = adv_a;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else
        begin
            if (adv_a)
                va_reg <= in_valid;
            if (adv_b)
                vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_a)
        begin
            pa_reg  <= in_pressed;
            mir_reg <= mir_next;
        end
        if (adv_b)
        begin
            pb_reg  <= pa_reg;
            fin_reg <= fin_next;
        end
    end

    assign out_valid = vb_reg;
    assign pressed   = pb_reg;
    assign screen_x  = fin_reg[0];
    assign screen_y  = fin_reg[1];

endmodule

`default_nettype wire

// File: sv/touch_coordinate_mapper.sv
// touch_coordinate_mapper: touch report to calibrated, oriented screen point.
// Pipeline: 2 front, 12 divider and 2 back register stages between input and output.
// Throughput: one item per cycle while out_stall is low; bubbles close.
// The 12-stage restoring divider (one quotient bit per stage) sets the depth.
// Reset: pipeline emptied, calibration registers at 0/4095/0/4095, screen 320x240,
// orientation and offsets zero. Uses tcm_pkg, tcm_front, tcm_div, tcm_post.
`timescale 1ns / 1ps
`default_nettype none

module touch_coordinate_mapper import tcm_pkg::*; #(
    parameter int RAW_COORD_BITS = 12
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_stall,
    input  wire logic                      read_ok,
    input  wire logic [7:0]                chip_x_high,
    input  wire logic [7:0]                chip_y_high,
    input  wire logic [7:0]                low_nibbles,
    input  wire logic [7:0]                count_byte,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic                           pressed,
    output logic [COORD_BITS-1:0]          screen_x,
    output logic [COORD_BITS-1:0]          screen_y
);

    localparam int RW = (RAW_COORD_BITS > COORD_BITS) ? RAW_COORD_BITS : COORD_BITS;
    localparam int PW = RW + COORD_BITS;

    logic [RW-1:0]                cal_lo_x_reg, cal_hi_x_reg, cal_lo_y_reg, cal_hi_y_reg;
    logic [SIZE_BITS-1:0]         width_reg, height_reg;
    logic [ORIENT_BITS-1:0]       orient_reg;
    logic [CFG_DATA_BITS-1:0]     offset_reg;
    logic [RW-1:0]                raw_next;
    post_cfg_t                    post_cfg;

    logic                                front_in_ready, front_valid, front_pressed;
    logic [NUM_AXES-1:0][PW-1:0]         front_prod;
    logic [NUM_AXES-1:0][RW-1:0]         front_span;
    logic                                div_in_ready, div_valid, div_pressed;
    logic [NUM_AXES-1:0][COORD_BITS-1:0] div_quot;
    logic                                post_in_ready;

    assign cfg_ready = 1'b1;
    assign raw_next  = RW'(cfg_data[RAW_COORD_BITS-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_lo_x_reg <= '0;
            cal_hi_x_reg <= RW'(12'hFFF);
            cal_lo_y_reg <= '0;
            cal_hi_y_reg <= RW'(12'hFFF);
            width_reg    <= 13'd320;
            height_reg   <= 13'd240;
            orient_reg   <= '0;
            offset_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_RAW_MIN_X:     cal_lo_x_reg <= raw_next;
                REG_RAW_MAX_X:     cal_hi_x_reg <= raw_next;
                REG_RAW_MIN_Y:     cal_lo_y_reg <= raw_next;
                REG_RAW_MAX_Y:     cal_hi_y_reg <= raw_next;
                REG_SCREEN_WIDTH:  width_reg    <= cfg_data[SIZE_BITS-1:0];
                REG_SCREEN_HEIGHT: height_reg   <= cfg_data[SIZE_BITS-1:0];
                REG_ORIENTATION:   orient_reg   <= cfg_data[ORIENT_BITS-1:0];
                REG_OFFSET_PAIR:   offset_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign post_cfg.wm1    = size_m1(width_reg);
    assign post_cfg.hm1    = size_m1(height_reg);
    assign post_cfg.orient = orient_reg;
    assign post_cfg.off_x  = offset_reg[OFFSET_BITS-1:0];
    assign post_cfg.off_y  = offset_reg[2*OFFSET_BITS-1:OFFSET_BITS];

    tcm_front #(.RAW_COORD_BITS(RAW_COORD_BITS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (front_in_ready),
        .read_ok     (read_ok),
        .chip_x_high (chip_x_high),
        .chip_y_high (chip_y_high),
        .low_nibbles (low_nibbles),
        .count_byte  (count_byte),
        .cal_lo_x    (cal_lo_x_reg),
        .cal_hi_x    (cal_hi_x_reg),
        .cal_lo_y    (cal_lo_y_reg),
        .cal_hi_y    (cal_hi_y_reg),
        .wm1         (post_cfg.wm1),
        .hm1         (post_cfg.hm1),
        .out_valid   (front_valid),
        .out_ready   (div_in_ready),
        .out_pressed (front_pressed),
        .out_prod    (front_prod),
        .out_span    (front_span)
    );

    tcm_div #(.RAW_COORD_BITS(RAW_COORD_BITS)) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (front_valid),
        .in_ready    (div_in_ready),
        .in_pressed  (front_pressed),
        .in_prod     (front_prod),
        .in_span     (front_span),
        .out_valid   (div_valid),
        .out_ready   (post_in_ready),
        .out_pressed (div_pressed),
        .out_quot    (div_quot)
    );

    tcm_post u_post (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (div_valid),
        .in_ready   (post_in_ready),
        .in_pressed (div_pressed),
        .in_quot    (div_quot),
        .cfg        (post_cfg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .pressed    (pressed),
        .screen_x   (screen_x),
        .screen_y   (screen_y)
    );

    assign in_stall = !front_in_ready;

    // a released item never shows a point
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pressed |-> screen_x == '0 && screen_y == '0)
        else $error("coordinates nonzero on a released item");

    // with the output slot empty every stage can move, so input is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while the output register is empty");

    // an empty front end always has room for a new item
    assert property (@(posedge clk) disable iff (!rst_n)
        !front_valid && !div_valid |-> !in_stall)
        else $error("input stalled with front and divider stages empty");

endmodule

`default_nettype wire
